### design/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int TREE_FANIN     = 8;
    localparam int TREE_MAX_LVL   = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic sel_en;
    } cell_ctl_t;

    // node count of one level of the or tree, level 0 being the leaves
    function automatic int level_width(input int leaves, input int lvl);
        int w;
        w = leaves;
        for (int i = 0; i < TREE_MAX_LVL; i++)
        begin
            if (i < lvl)
            begin
                w = (w + TREE_FANIN - 1) / TREE_FANIN;
            end
        end
        return w;
    endfunction

    function automatic int tree_levels(input int leaves);
        int w;
        int lv;
        w  = leaves;
        lv = 0;
        for (int i = 0; i < TREE_MAX_LVL; i++)
        begin
            if (w > 1 || lv == 0)
            begin
                w  = (w + TREE_FANIN - 1) / TREE_FANIN;
                lv = lv + 1;
            end
        end
        return lv;
    endfunction

    // first node index of a level in the flattened node array
    function automatic int level_offset(input int leaves, input int lvl);
        int off;
        off = 0;
        for (int i = 1; i < TREE_MAX_LVL; i++)
        begin
            if (i < lvl)
            begin
                off = off + level_width(leaves, i);
            end
        end
        return off;
    endfunction

endpackage

### design/ple_cell.sv
module ple_cell #(
    parameter int ITEM_WIDTH = ple_pkg::ITEM_WIDTH_DEF,
    parameter int IDX_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ple_pkg::cell_ctl_t    ctl,
    input  logic [IDX_W-1:0]      sel_idx,
    input  logic [ITEM_WIDTH-1:0] ins_value,
    input  logic [ITEM_WIDTH-1:0] lower_value,
    input  logic [ITEM_WIDTH-1:0] upper_value,
    output logic [ITEM_WIDTH-1:0] value,
    output logic [ITEM_WIDTH-1:0] tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ITEM_WIDTH-1:0] value_reg;
    logic [ITEM_WIDTH-1:0] value_next;
    logic                  above;
    logic                  here;

    assign here  = (sel_idx == MY_IDX);
    assign above = (MY_IDX > sel_idx);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins_en)
        begin
            if (here)
            begin
                value_next = ins_value;
            end
            else if (above)
            begin
                value_next = lower_value;
            end
        end
        else if (ctl.del_en)
        begin
            if (here || above)
            begin
                value_next = upper_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (ctl.sel_en && here) ? value_reg : '0;

endmodule

### design/ple_or_tree.sv
module ple_or_tree #(
    parameter int ITEM_WIDTH = ple_pkg::ITEM_WIDTH_DEF,
    parameter int LEAVES     = ple_pkg::CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [ITEM_WIDTH-1:0] leaves [LEAVES],
    output logic [ITEM_WIDTH-1:0] root
);

    localparam int FANIN  = ple_pkg::TREE_FANIN;
    localparam int LEVELS = ple_pkg::tree_levels(LEAVES);
    localparam int W1     = ple_pkg::level_width(LEAVES, 1);
    localparam int NODES  = ple_pkg::level_offset(LEAVES, LEVELS + 1);

    logic [ITEM_WIDTH-1:0] node_reg  [NODES];
    logic [ITEM_WIDTH-1:0] node_next [NODES];

    // first level captures only on a transfer, upper levels follow every cycle
    always_comb
    begin
        logic [ITEM_WIDTH-1:0] acc;
        acc       = '0;
        node_next = node_reg;
        if (load)
        begin
            for (int j = 0; j < W1; j++)
            begin
                acc = '0;
                for (int k = 0; k < FANIN; k++)
                begin
                    if (FANIN * j + k < LEAVES)
                    begin
                        acc = acc | leaves[FANIN * j + k];
                    end
                end
                node_next[j] = acc;
            end
        end
        for (int l = 2; l <= LEVELS; l++)
        begin
            for (int j = 0; j < W1; j++)
            begin
                if (j < ple_pkg::level_width(LEAVES, l))
                begin
                    acc = '0;
                    for (int k = 0; k < FANIN; k++)
                    begin
                        if (FANIN * j + k < ple_pkg::level_width(LEAVES, l - 1))
                        begin
                            acc = acc | node_reg[ple_pkg::level_offset(LEAVES, l - 1)
                                                 + FANIN * j + k];
                        end
                    end
                    node_next[ple_pkg::level_offset(LEAVES, l) + j] = acc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign root = node_reg[NODES-1];

endmodule

### design/positional_list_engine_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  action, position, item_value
// rsp       out        rsp_valid / rsp_stall  status, item_out, fill_count, is_empty
//
// one request in flight; LEVELS is the depth of the registered 8-way or tree
// that picks the addressed entry (2 levels at 64 entries); on insert or delete
// the entries from the addressed position up shift in the transfer cycle
// rst_n clears the fill count and control, entry contents are left as they are
// rsp_stall holds the finished result in the output register; req_stall stays
// high until that register can take the next result

module positional_list_engine_unit #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = ple_pkg::ITEM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  action,
    input  logic [6:0]  position,
    input  logic [31:0] item_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] item_out,
    output logic [6:0]  fill_count,
    output logic        is_empty
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam int LEVELS = ple_pkg::tree_levels(CAPACITY);
    localparam int LAT_W  = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t               state_reg,  state_next;
    logic [LAT_W-1:0]     lat_reg,    lat_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    ple_pkg::status_t     pend_reg,   pend_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [1:0]           rsp_status_reg, rsp_status_next;
    logic [31:0]          rsp_item_reg,   rsp_item_next;
    logic [6:0]           rsp_fill_reg,   rsp_fill_next;
    logic                 rsp_empty_reg,  rsp_empty_next;

    logic                 accept;
    logic                 out_free;
    ple_pkg::action_t     act;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    ple_pkg::status_t     status_c;
    logic [CNT_W-1:0]     cnt_c;
    ple_pkg::cell_ctl_t   ctl_c;
    ple_pkg::cell_ctl_t   cell_ctl;
    logic [IDX_W-1:0]     sel_idx;
    logic [ITEM_WIDTH-1:0] ins_value;
    logic [ITEM_WIDTH-1:0] cell_value [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_tap   [CAPACITY];
    logic [ITEM_WIDTH-1:0] root;
    logic [31:0]          root32;
    logic [6:0]           cnt7;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign act      = ple_pkg::action_t'(action);
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign sel_idx  = IDX_W'(pos_ext - CMP_W'(1));

    generate
        if (ITEM_WIDTH <= 32)
        begin : g_in_narrow
            assign ins_value = item_value[ITEM_WIDTH-1:0];
        end
        else
        begin : g_in_wide
            assign ins_value = ITEM_WIDTH'(item_value);
        end
        if (ITEM_WIDTH >= 32)
        begin : g_out_wide
            assign root32 = root[31:0];
        end
        else
        begin : g_out_narrow
            assign root32 = 32'(root);
        end
        if (CNT_W >= 7)
        begin : g_cnt_wide
            assign cnt7 = cnt_reg[6:0];
        end
        else
        begin : g_cnt_narrow
            assign cnt7 = 7'(cnt_reg);
        end
    endgenerate

    // request decode against the current fill count
    always_comb
    begin
        status_c = ple_pkg::ST_OK;
        cnt_c    = cnt_reg;
        ctl_c    = '0;
        case (act)
            ple_pkg::ACT_INSERT:
            begin
                if (cnt_reg == CNT_W'(CAPACITY))
                begin
                    status_c = ple_pkg::ST_FULL;
                end
                else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                begin
                    status_c = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    ctl_c.ins_en = 1'b1;
                    cnt_c        = cnt_reg + CNT_W'(1);
                end
            end
            ple_pkg::ACT_DELETE, ple_pkg::ACT_READ:
            begin
                if (cnt_reg == '0)
                begin
                    status_c = ple_pkg::ST_EMPTY;
                end
                else if (pos_ext == '0 || pos_ext > cnt_ext)
                begin
                    status_c = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    ctl_c.sel_en = 1'b1;
                    if (act == ple_pkg::ACT_DELETE)
                    begin
                        ctl_c.del_en = 1'b1;
                        cnt_c        = cnt_reg - CNT_W'(1);
                    end
                end
            end
            ple_pkg::ACT_CLEAR:
            begin
                cnt_c = '0;
            end
            default:
            begin
                cnt_c = cnt_reg;
            end
        endcase
    end

    assign cell_ctl = accept ? ctl_c : '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [ITEM_WIDTH-1:0] lower_value;
            logic [ITEM_WIDTH-1:0] upper_value;
            if (i == 0)
            begin : g_first
                assign lower_value = ins_value;
            end
            else
            begin : g_lower
                assign lower_value = cell_value[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign upper_value = cell_value[i];
            end
            else
            begin : g_upper
                assign upper_value = cell_value[i+1];
            end
            ple_cell #(
                .ITEM_WIDTH (ITEM_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (i)
            ) u_cell (
                .clk         (clk),
                .ctl         (cell_ctl),
                .sel_idx     (sel_idx),
                .ins_value   (ins_value),
                .lower_value (lower_value),
                .upper_value (upper_value),
                .value       (cell_value[i]),
                .tap         (cell_tap[i])
            );
        end
    endgenerate

    ple_or_tree #(
        .ITEM_WIDTH (ITEM_WIDTH),
        .LEAVES     (CAPACITY)
    ) u_or_tree (
        .clk    (clk),
        .load   (accept),
        .leaves (cell_tap),
        .root   (root)
    );

    always_comb
    begin
        state_next      = state_reg;
        lat_next        = lat_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_item_next   = rsp_item_reg;
        rsp_fill_next   = rsp_fill_reg;
        rsp_empty_next  = rsp_empty_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DRAIN;
                    lat_next   = LAT_W'(LEVELS - 1);
                    cnt_next   = cnt_c;
                    pend_next  = status_c;
                end
            end
            S_DRAIN:
            begin
                if (lat_reg != '0)
                begin
                    lat_next = lat_reg - LAT_W'(1);
                end
                else if (out_free)
                begin
                    state_next      = S_IDLE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = pend_reg;
                    rsp_item_next   = root32;
                    rsp_fill_next   = cnt7;
                    rsp_empty_next  = (cnt_reg == '0);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lat_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lat_reg       <= lat_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg       <= pend_next;
        rsp_status_reg <= rsp_status_next;
        rsp_item_reg   <= rsp_item_next;
        rsp_fill_reg   <= rsp_fill_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign item_out   = rsp_item_reg;
    assign fill_count = rsp_fill_reg;
    assign is_empty   = rsp_empty_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_cnt_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(accept))
        else $error("fill count changed without a request transfer");

    a_err_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status_reg != ple_pkg::ST_OK) |-> (item_out == '0))
        else $error("nonzero item on an error result");

    a_drain_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DRAIN && lat_reg == LAT_W'(LEVELS - 1)))
        else $error("request transfer did not start the tree drain");

endmodule

### bench/list_result_checker.sv
module list_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  action,
    input  logic [6:0]  position,
    input  logic [31:0] item_value,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [1:0]  status,
    input  logic [31:0] item_out,
    input  logic [6:0]  fill_count,
    input  logic        is_empty,
    output int          fail_count,
    output int          pending
);

    localparam int CAP = ple_pkg::CAPACITY_DEF;
    localparam logic [31:0] ITEM_MASK = 32'hFFFF_FFFF >> (32 - ple_pkg::ITEM_WIDTH_DEF);

    typedef struct {
        ple_pkg::status_t st;
        logic [31:0]      val;
        logic [6:0]       cnt;
        logic             emp;
    } list_result_t;

    logic [31:0]  list_store [CAP];
    int           list_len = 0;
    list_result_t result_q [$];
    list_result_t oldest;

    function automatic list_result_t apply_request(input ple_pkg::action_t a, input int p,
                                                   input logic [31:0] v);
        list_result_t r;
        r.st  = ple_pkg::ST_OK;
        r.val = '0;
        case (a)
            ple_pkg::ACT_INSERT:
            begin
                if (list_len >= CAP)
                begin
                    r.st = ple_pkg::ST_FULL;
                end
                else if (p == 0 || p > list_len + 1)
                begin
                    r.st = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    for (int i = list_len; i >= p; i--)
                    begin
                        list_store[i] = list_store[i - 1];
                    end
                    list_store[p - 1] = v & ITEM_MASK;
                    list_len++;
                end
            end
            ple_pkg::ACT_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
                if (list_len == 0)
                begin
                    r.st = ple_pkg::ST_EMPTY;
                end
                else if (p == 0 || p > list_len)
                begin
                    r.st = ple_pkg::ST_BADPOS;
                end
                else
                begin
                    r.val = list_store[p - 1];
                    if (a == ple_pkg::ACT_DELETE)
                    begin
                        for (int i = p; i < list_len; i++)
                        begin
                            list_store[i - 1] = list_store[i];
                        end
                        list_len--;
                    end
                end
            end
        endcase
        r.cnt = list_len[6:0];
        r.emp = (list_len == 0);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (result_q.size() == 0)
                begin
                    note_failure($sformatf(
                        "unexpected result status=%0d item=%h count=%0d empty=%b",
                        status, item_out, fill_count, is_empty));
                end
                else
                begin
                    oldest = result_q.pop_front();
                    if (status !== oldest.st || item_out !== oldest.val
                        || fill_count !== oldest.cnt || is_empty !== oldest.emp)
                    begin
                        note_failure($sformatf(
                            {"mismatch: expected status=%0d item=%h count=%0d empty=%b,",
                             " got status=%0d item=%h count=%0d empty=%b"},
                            oldest.st, oldest.val, oldest.cnt, oldest.emp,
                            status, item_out, fill_count, is_empty));
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                result_q.push_back(apply_request(ple_pkg::action_t'(action),
                                                 int'(position), item_value));
            end
            pending <= result_q.size();
        end
    end

endmodule

### bench/positional_list_engine_unit_test.sv
module positional_list_engine_unit_test;

    localparam int CAP = ple_pkg::CAPACITY_DEF;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_valid  = 1'b0;
    logic        req_stall;
    logic [1:0]  action     = ple_pkg::ACT_INSERT;
    logic [6:0]  position   = '0;
    logic [31:0] item_value = '0;
    logic        rsp_valid;
    logic        rsp_stall  = 1'b0;
    logic [1:0]  status;
    logic [31:0] item_out;
    logic [6:0]  fill_count;
    logic        is_empty;

    int fail_count;
    int pending;
    int list_len  = 0;
    bit quiet     = 1'b0;
    int hold_req  = 0;
    int hold_done = 0;

    positional_list_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .position   (position),
        .item_value (item_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .item_out   (item_out),
        .fill_count (fill_count),
        .is_empty   (is_empty)
    );

    list_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .position   (position),
        .item_value (item_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .item_out   (item_out),
        .fill_count (fill_count),
        .is_empty   (is_empty),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // offer one request, hold it until the transfer, then maybe idle
    task automatic issue(input ple_pkg::action_t a, input int p, input logic [31:0] v);
        req_valid  <= 1'b1;
        action     <= a;
        position   <= p[6:0];
        item_value <= v;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        case (a)
            ple_pkg::ACT_INSERT:
            begin
                if (list_len < CAP && p >= 1 && p <= list_len + 1)
                begin
                    list_len++;
                end
            end
            ple_pkg::ACT_DELETE:
            begin
                if (list_len > 0 && p >= 1 && p <= list_len)
                begin
                    list_len--;
                end
            end
            ple_pkg::ACT_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
            end
        endcase
        if (!quiet && $urandom_range(99) < 27)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int pick_pos(input int hi);
        if (hi >= 1 && $urandom_range(99) < 85)
        begin
            return $urandom_range(1, hi);
        end
        case ($urandom_range(5))
            0:       return 0;
            1:       return hi + 1;
            2:       return 64;
            3:       return 65;
            4:       return 127;
            default: return $urandom_range(127);
        endcase
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_items(input int n, input int ins_w, input int del_w);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 2)
            begin
                issue(ple_pkg::ACT_CLEAR, $urandom_range(127), pick_val());
            end
            else if (r < 2 + ins_w)
            begin
                issue(ple_pkg::ACT_INSERT, pick_pos(list_len + 1), pick_val());
            end
            else if (r < 2 + ins_w + del_w)
            begin
                issue(ple_pkg::ACT_DELETE, pick_pos(list_len), pick_val());
            end
            else
            begin
                issue(ple_pkg::ACT_READ, pick_pos(list_len), pick_val());
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver side stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_req)
            begin
                hold_done++;
                rsp_stall <= 1'b1;
                repeat (60) @(posedge clk);
            end
            else if (quiet)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < 27);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, ends of the list
        issue(ple_pkg::ACT_READ, 1, 32'h0);
        issue(ple_pkg::ACT_DELETE, 0, 32'h0);
        issue(ple_pkg::ACT_DELETE, 127, 32'h0);
        issue(ple_pkg::ACT_INSERT, 0, 32'h1234_5678);
        issue(ple_pkg::ACT_INSERT, 2, 32'h1234_5678);
        issue(ple_pkg::ACT_INSERT, 1, 32'h0000_0000);
        issue(ple_pkg::ACT_INSERT, 1, 32'hFFFF_FFFF);
        issue(ple_pkg::ACT_INSERT, 3, 32'hA5A5_A5A5);
        issue(ple_pkg::ACT_INSERT, 2, 32'h5A5A_5A5A);
        issue(ple_pkg::ACT_INSERT, 127, 32'h1);
        issue(ple_pkg::ACT_READ, 0, 32'h0);
        issue(ple_pkg::ACT_READ, 4, 32'h0);
        issue(ple_pkg::ACT_READ, 5, 32'h0);
        issue(ple_pkg::ACT_DELETE, 5, 32'h0);
        issue(ple_pkg::ACT_DELETE, 0, 32'h0);
        issue(ple_pkg::ACT_DELETE, 1, 32'h0);
        issue(ple_pkg::ACT_DELETE, 3, 32'h0);
        issue(ple_pkg::ACT_READ, 1, 32'h0);
        issue(ple_pkg::ACT_CLEAR, 0, 32'h0);
        issue(ple_pkg::ACT_READ, 1, 32'h0);
        issue(ple_pkg::ACT_CLEAR, 127, 32'hFFFF_FFFF);

        random_items(200, 55, 15);

        // fill to capacity with no idling while the receiver holds off
        quiet = 1'b1;
        hold_req++;
        while (list_len < CAP)
        begin
            issue(ple_pkg::ACT_INSERT, $urandom_range(1, list_len + 1), pick_val());
        end
        issue(ple_pkg::ACT_INSERT, 0, pick_val());
        issue(ple_pkg::ACT_INSERT, 127, pick_val());
        issue(ple_pkg::ACT_INSERT, 65, pick_val());
        issue(ple_pkg::ACT_INSERT, 1, pick_val());
        issue(ple_pkg::ACT_READ, 64, 32'h0);
        issue(ple_pkg::ACT_READ, 65, 32'h0);
        issue(ple_pkg::ACT_DELETE, 64, 32'h0);
        issue(ple_pkg::ACT_INSERT, 64, pick_val());
        issue(ple_pkg::ACT_INSERT, 33, pick_val());
        issue(ple_pkg::ACT_DELETE, 1, 32'h0);
        issue(ple_pkg::ACT_READ, 0, 32'h0);
        random_items(40, 40, 20);
        quiet = 1'b0;

        // sender waits for every outstanding result
        req_valid <= 1'b0;
        drain();

        random_items(200, 15, 55);
        random_items(150, 40, 30);
        hold_req++;
        random_items(150, 40, 30);

        req_valid <= 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
